>>> hw/rtl/utf8_char_decoder_macros.svh
// assertion macros for the utf8 character decoder
// expects clk and rst_n in the scope of the including module
`ifndef UTF8_CHAR_DECODER_MACROS_SVH
`define UTF8_CHAR_DECODER_MACROS_SVH

// same-cycle implication
`define U8D_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define U8D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/utf8d_pkg.sv
// shared widths, constants, stage types and helpers for the utf8 decoder
// no dependencies
package utf8d_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int LEN_W  = 3;

  localparam logic [CP_W-1:0] QMARK      = 21'h00003F;
  localparam logic [CP_W-1:0] CP_LIMIT   = 21'h110000;
  localparam logic [CP_W-1:0] SURR_BASE  = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_SPAN  = 21'h0007FF;
  localparam logic [CP_W-1:0] NCHR_BASE  = 21'h00FDD0;
  localparam logic [CP_W-1:0] NCHR_SPAN  = 21'h00001F;
  localparam logic [15:0]     NCHR_LOW16 = 16'hFFFE;
  localparam logic [CP_W-1:0] JOIN_BASE  = 21'h010000;
  localparam logic [CP_W-1:0] MIN_TWO    = 21'h000080;
  localparam logic [CP_W-1:0] MIN_THREE  = 21'h000800;
  localparam logic [CP_W-1:0] MIN_FOUR   = 21'h010000;

  localparam logic [15:0] HI_SURR_LO = 16'hD800;
  localparam logic [15:0] HI_SURR_HI = 16'hDC00;

  localparam logic [BYTE_W-1:0] LEAD_MIN     = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD_MAX     = 8'hF7;
  localparam logic [BYTE_W-1:0] LEAD_THREE   = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_FOUR    = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD_SURR    = 8'hED;
  localparam logic [3:0]        LOW_SURR_HI4 = 4'hB;

  localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
  localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
  localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
  localparam logic [LEN_W-1:0] LEN_4 = 3'd4;
  localparam logic [LEN_W-1:0] LEN_6 = 3'd6;

  typedef enum logic [1:0] {
    MIN_NONE,
    MIN_2B,
    MIN_3B,
    MIN_4B
  } min_sel_t;

  // stage 1: byte classification and field extraction
  typedef struct packed {
    logic        ascii;
    logic [6:0]  ascii_val;
    logic        lead_ok;
    logic        is3;
    logic        is4;
    logic [2:0]  cont;
    logic [10:0] v2;
    logic [15:0] v3;
    logic [20:0] v4;
    logic        pair_ok;
    logic [9:0]  pair_hi;
    logic [3:0]  pair_lo;
    logic [5:0]  pair_tail;
  } s1_t;

  // stage 2: selected value, length and early error
  typedef struct packed {
    logic [CP_W-1:0]  val;
    logic [LEN_W-1:0] len;
    logic             err;
    min_sel_t         min_sel;
  } s2_t;

  // stage 3: result item
  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] bytes_used;
    logic             decode_error;
    logic             pair_joined;
    logic             strict_ok;
  } s3_t;

  function automatic logic is_cont(input logic [BYTE_W-1:0] b);
    return b[7:6] == 2'b10;
  endfunction

  function automatic logic [CP_W-1:0] min_of(input min_sel_t sel);
    logic [CP_W-1:0] m;
    unique case (sel)
      MIN_2B:  m = MIN_TWO;
      MIN_3B:  m = MIN_THREE;
      MIN_4B:  m = MIN_FOUR;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic scalar_ok(input logic [CP_W-1:0] v);
    logic below_max;
    logic not_surr;
    logic not_nchr_tail;
    logic not_nchr_blk;
    below_max     = v < CP_LIMIT;
    not_surr      = (v - SURR_BASE) > SURR_SPAN;
    not_nchr_tail = v[15:0] < NCHR_LOW16;
    not_nchr_blk  = (v - NCHR_BASE) > NCHR_SPAN;
    return below_max && not_surr && not_nchr_tail && not_nchr_blk;
  endfunction

endpackage

>>> hw/rtl/utf8d_in_if.sv
// input channel: six-byte window with valid/ready
// depends on utf8d_pkg
interface utf8d_in_if;
  import utf8d_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_first;
  logic [BYTE_W-1:0] byte_second;
  logic [BYTE_W-1:0] byte_third;
  logic [BYTE_W-1:0] byte_fourth;
  logic [BYTE_W-1:0] byte_fifth;
  logic [BYTE_W-1:0] byte_sixth;

  modport source (
    output valid, byte_first, byte_second, byte_third, byte_fourth, byte_fifth, byte_sixth,
    input  ready
  );

  modport sink (
    input  valid, byte_first, byte_second, byte_third, byte_fourth, byte_fifth, byte_sixth,
    output ready
  );
endinterface

>>> hw/rtl/utf8d_out_if.sv
// result channel: decoded character with valid/ready
// depends on utf8d_pkg
interface utf8d_out_if;
  import utf8d_pkg::*;

  logic             valid;
  logic             ready;
  logic [CP_W-1:0]  code_point;
  logic [LEN_W-1:0] bytes_used;
  logic             decode_error;
  logic             pair_joined;
  logic             strict_ok;

  modport source (
    output valid, code_point, bytes_used, decode_error, pair_joined, strict_ok,
    input  ready
  );

  modport sink (
    input  valid, code_point, bytes_used, decode_error, pair_joined, strict_ok,
    output ready
  );
endinterface

>>> hw/rtl/utf8_char_decoder.sv
// utf8 character decoder top level, three-stage pipeline
// depends on utf8d_pkg, utf8d_in_if, utf8d_out_if and the macros header
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+-------------------------------------------------
//   in_ch    | in  | valid/ready  | byte_first .. byte_sixth
//   out_ch   | out | valid/ready  | code_point, bytes_used, decode_error,
//            |     |              | pair_joined, strict_ok
//
// one character per cycle sustained while out_ch.ready is high; three register stages
// (classify, assemble and join, validate); an accepted input passes through the
// stage 1, stage 2 and result registers in order before it shows on out_ch
// rst_n clears the three stage valid bits only
// each stage loads when it is empty or its successor moves on, so a stall
// on out_ch backs up stage by stage and in_ch.ready drops once all are full
// and out_ch.ready is low
`include "utf8_char_decoder_macros.svh"

module utf8_char_decoder (
  input  logic        clk,
  input  logic        rst_n,
  utf8d_in_if.sink    in_ch,
  utf8d_out_if.source out_ch
);
  import utf8d_pkg::*;

  logic v1_r, v1_nxt;
  logic v2_r, v2_nxt;
  logic v3_r, v3_nxt;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;

  logic adv1, adv2, adv3;
  logic in_xfer;

  assign adv3    = !v3_r || out_ch.ready;
  assign adv2    = !v2_r || adv3;
  assign adv1    = !v1_r || adv2;
  assign in_xfer = in_ch.valid && adv1;

  assign in_ch.ready = adv1;

  // stage 1: classify bytes
  always_comb begin
    s1_nxt           = '0;
    s1_nxt.ascii     = !in_ch.byte_first[7];
    s1_nxt.ascii_val = in_ch.byte_first[6:0];
    s1_nxt.lead_ok   = (in_ch.byte_first >= LEAD_MIN) && (in_ch.byte_first <= LEAD_MAX);
    s1_nxt.is3       = in_ch.byte_first >= LEAD_THREE;
    s1_nxt.is4       = in_ch.byte_first >= LEAD_FOUR;
    s1_nxt.cont      = {is_cont(in_ch.byte_fourth), is_cont(in_ch.byte_third),
                        is_cont(in_ch.byte_second)};
    s1_nxt.v2        = {in_ch.byte_first[4:0], in_ch.byte_second[5:0]};
    s1_nxt.v3        = {in_ch.byte_first[3:0], in_ch.byte_second[5:0], in_ch.byte_third[5:0]};
    s1_nxt.v4        = {in_ch.byte_first[2:0], in_ch.byte_second[5:0],
                        in_ch.byte_third[5:0], in_ch.byte_fourth[5:0]};
    s1_nxt.pair_ok   = (s1_nxt.v3 >= HI_SURR_LO) && (s1_nxt.v3 < HI_SURR_HI)
                       && (in_ch.byte_fourth == LEAD_SURR)
                       && (in_ch.byte_fifth[7:4] == LOW_SURR_HI4)
                       && is_cont(in_ch.byte_sixth);
    s1_nxt.pair_hi   = s1_nxt.v3[9:0];
    s1_nxt.pair_lo   = in_ch.byte_fifth[3:0];
    s1_nxt.pair_tail = in_ch.byte_sixth[5:0];
  end

  // stage 2: pick the form, join a surrogate pair
  always_comb begin
    logic [CP_W-1:0] joined;
    joined          = JOIN_BASE + {1'b0, s1_r.pair_hi, s1_r.pair_lo, s1_r.pair_tail};
    s2_nxt.val      = '0;
    s2_nxt.len      = LEN_1;
    s2_nxt.err      = 1'b0;
    s2_nxt.min_sel  = MIN_NONE;
    if (s1_r.ascii) begin
      s2_nxt.val = {14'd0, s1_r.ascii_val};
    end else if (!s1_r.lead_ok || !s1_r.cont[0]) begin
      s2_nxt.err = 1'b1;
    end else if (!s1_r.is3) begin
      s2_nxt.val     = {10'd0, s1_r.v2};
      s2_nxt.len     = LEN_2;
      s2_nxt.min_sel = MIN_2B;
    end else if (!s1_r.cont[1]) begin
      s2_nxt.err = 1'b1;
      s2_nxt.len = LEN_2;
    end else if (!s1_r.is4) begin
      if (s1_r.pair_ok) begin
        s2_nxt.val     = joined;
        s2_nxt.len     = LEN_6;
        s2_nxt.min_sel = MIN_4B;
      end else begin
        s2_nxt.val     = {5'd0, s1_r.v3};
        s2_nxt.len     = LEN_3;
        s2_nxt.min_sel = MIN_3B;
      end
    end else if (!s1_r.cont[2]) begin
      s2_nxt.err = 1'b1;
      s2_nxt.len = LEN_3;
    end else begin
      s2_nxt.val     = s1_r.v4;
      s2_nxt.len     = LEN_4;
      s2_nxt.min_sel = MIN_4B;
    end
  end

  // stage 3: overlong and scalar checks, result item
  always_comb begin
    logic bad;
    bad = (s2_r.min_sel != MIN_NONE)
          && ((s2_r.val < min_of(s2_r.min_sel)) || !scalar_ok(s2_r.val));
    s3_nxt.decode_error = s2_r.err || bad;
    s3_nxt.code_point   = s3_nxt.decode_error ? QMARK : s2_r.val;
    s3_nxt.bytes_used   = s2_r.len;
    s3_nxt.pair_joined  = s2_r.len == LEN_6;
    s3_nxt.strict_ok    = !s3_nxt.decode_error && (s2_r.len != LEN_6);
  end

  always_comb begin
    v1_nxt = adv1 ? in_ch.valid : v1_r;
    v2_nxt = adv2 ? v1_r : v2_r;
    v3_nxt = adv3 ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_r <= s1_nxt;
    end
    if (adv2 && v1_r) begin
      s2_r <= s2_nxt;
    end
    if (adv3 && v2_r) begin
      s3_r <= s3_nxt;
    end
  end

  assign out_ch.valid        = v3_r;
  assign out_ch.code_point   = s3_r.code_point;
  assign out_ch.bytes_used   = s3_r.bytes_used;
  assign out_ch.decode_error = s3_r.decode_error;
  assign out_ch.pair_joined  = s3_r.pair_joined;
  assign out_ch.strict_ok    = s3_r.strict_ok;

  `U8D_ASSERT_SAME(a_err_gives_qmark, out_ch.valid && out_ch.decode_error, out_ch.code_point == QMARK, "error result without question mark")
  `U8D_ASSERT_SAME(a_pair_six_bytes, out_ch.valid && out_ch.pair_joined, out_ch.bytes_used == LEN_6, "joined pair not six bytes")
  `U8D_ASSERT_NEXT(a_xfer_enters_pipe, in_ch.valid && in_ch.ready, v1_r, "accepted transfer missing from first stage")
  `U8D_ASSERT_SAME(a_full_blocks_input, v1_r && v2_r && v3_r && !out_ch.ready, !in_ch.ready, "input taken while pipeline full and stalled")

endmodule
